// ----- rtl/core/mmie_pkg.sv -----
// shared types, constants and helpers of the memory machine instruction executor
`timescale 1ns / 1ps

package mmie_pkg;

    // data memory geometry, word 0 is the program counter
    // (MEM_WORDS is kept a power of two so that address forming keeps the low operand bits)
    localparam int MEM_WORDS = 1024;
    localparam int ADDR_W    = $clog2(MEM_WORDS);
    localparam int DATA_W    = 32;

    // opcodes
    localparam logic [3:0] OP_NOP  = 4'd1;
    localparam logic [3:0] OP_SET  = 4'd2;
    localparam logic [3:0] OP_CPY  = 4'd3;
    localparam logic [3:0] OP_CPYI = 4'd4;
    localparam logic [3:0] OP_ADD  = 4'd5;
    localparam logic [3:0] OP_ADDI = 4'd6;
    localparam logic [3:0] OP_SUBI = 4'd7;
    localparam logic [3:0] OP_JIF  = 4'd8;
    localparam logic [3:0] OP_HLT  = 4'd9;

    typedef struct packed {
        logic        [3:0]  kind;
        logic signed [31:0] first_operand;
        logic signed [31:0] second_operand;
    } t_in;

    typedef struct packed {
        logic               ok;
        logic               halted;
        logic signed [31:0] next_pc;
    } t_out;

    // one access of the single data memory port
    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } t_mem_req;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [DATA_W-1:0] operand);
        return operand[ADDR_W-1:0];
    endfunction

endpackage

// ----- rtl/core/mmie_ram.sv -----
// generic single-port synchronous ram with registered read data
`timescale 1ns / 1ps

module mmie_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/mmie_exec.sv -----
// instruction sequencer: clearing sweep, operand reads, execute and write back
`timescale 1ns / 1ps

module mmie_exec (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  mmie_pkg::t_in                  i_item,
    output logic                           busy,
    output logic                           o_done,
    output mmie_pkg::t_out                 o_result,
    output mmie_pkg::t_mem_req             o_mem_req,
    input  logic [mmie_pkg::DATA_W-1:0]    i_mem_rdata
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RD1   = 5'b00100,
        S_RD2   = 5'b01000,
        S_EXEC  = 5'b10000
    } t_state;

    t_state                          r_state, n_state;
    logic [mmie_pkg::ADDR_W-1:0]     r_clr, n_clr;
    logic [mmie_pkg::DATA_W-1:0]     r_pc, n_pc;
    logic                            r_rd_zero, n_rd_zero;
    logic                            r_done, n_done;
    mmie_pkg::t_in                   r_item, n_item;
    logic [mmie_pkg::DATA_W-1:0]     r_v, n_v;
    logic [mmie_pkg::DATA_W-1:0]     r_w, n_w;
    mmie_pkg::t_out                  r_result, n_result;

    logic [mmie_pkg::DATA_W-1:0]     rd_val;
    logic [mmie_pkg::DATA_W-1:0]     wval;
    logic [mmie_pkg::DATA_W-1:0]     pc_mid;
    logic [mmie_pkg::ADDR_W-1:0]     dst;
    logic                            do_wr;
    logic                            jif_take;
    logic                            ok;
    logic                            halted;

    // word 0 lives in r_pc, so a read of address 0 is served from it
    assign rd_val = r_rd_zero ? r_pc : i_mem_rdata;
    assign dst    = mmie_pkg::addr_of(r_item.second_operand);

    // execute-stage decode
    always_comb begin
        wval     = '0;
        do_wr    = 1'b0;
        jif_take = 1'b0;
        ok       = 1'b1;
        halted   = 1'b0;
        unique case (r_item.kind)
            mmie_pkg::OP_NOP: begin
            end
            mmie_pkg::OP_SET: begin
                wval  = r_item.first_operand;
                do_wr = 1'b1;
            end
            mmie_pkg::OP_CPY: begin
                wval  = r_v;
                do_wr = 1'b1;
            end
            mmie_pkg::OP_CPYI: begin
                wval  = r_w;
                do_wr = 1'b1;
            end
            mmie_pkg::OP_ADD: begin
                wval  = r_v + r_item.first_operand;
                do_wr = 1'b1;
            end
            mmie_pkg::OP_ADDI: begin
                wval  = r_v + r_w;
                do_wr = 1'b1;
            end
            mmie_pkg::OP_SUBI: begin
                wval  = r_v - r_w;
                do_wr = 1'b1;
            end
            mmie_pkg::OP_JIF: begin
                jif_take = (r_v == '0) || r_v[mmie_pkg::DATA_W-1];
            end
            mmie_pkg::OP_HLT: begin
                halted = 1'b1;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    // counter value after the operation, before the advance rule
    always_comb begin
        if (do_wr && dst == '0) begin
            pc_mid = wval;
        end else if (jif_take) begin
            pc_mid = r_item.second_operand;
        end else begin
            pc_mid = r_pc;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_pc      = r_pc;
        n_rd_zero = r_rd_zero;
        n_done    = 1'b0;
        n_item    = r_item;
        n_v       = r_v;
        n_w       = r_w;
        n_result  = r_result;
        o_mem_req = '0;

        unique case (r_state)
            S_CLEAR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.addr  = r_clr;
                o_mem_req.wdata = '0;
                n_clr           = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_item  = i_item;
                    n_state = S_RD1;
                    unique case (i_item.kind)
                        mmie_pkg::OP_CPY, mmie_pkg::OP_CPYI, mmie_pkg::OP_ADDI,
                        mmie_pkg::OP_SUBI, mmie_pkg::OP_JIF: begin
                            o_mem_req.addr = mmie_pkg::addr_of(i_item.first_operand);
                        end
                        mmie_pkg::OP_ADD: begin
                            o_mem_req.addr = mmie_pkg::addr_of(i_item.second_operand);
                        end
                        default: begin
                            n_state = S_EXEC;
                        end
                    endcase
                    o_mem_req.re = (n_state == S_RD1);
                    n_rd_zero    = (o_mem_req.addr == '0);
                end
            end
            S_RD1: begin
                n_v     = rd_val;
                n_state = S_EXEC;
                if (r_item.kind == mmie_pkg::OP_CPYI) begin
                    o_mem_req.re   = 1'b1;
                    o_mem_req.addr = mmie_pkg::addr_of(rd_val);
                    n_state        = S_RD2;
                end else if (r_item.kind == mmie_pkg::OP_ADDI ||
                             r_item.kind == mmie_pkg::OP_SUBI) begin
                    o_mem_req.re   = 1'b1;
                    o_mem_req.addr = dst;
                    n_state        = S_RD2;
                end
                n_rd_zero = (o_mem_req.addr == '0);
            end
            S_RD2: begin
                n_w     = rd_val;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (do_wr && dst != '0) begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.addr  = dst;
                    o_mem_req.wdata = wval;
                end
                n_pc             = (pc_mid == r_pc) ? r_pc + 32'd1 : pc_mid;
                n_result.ok      = ok;
                n_result.halted  = halted;
                n_result.next_pc = n_pc;
                n_done           = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_pc      <= '0;
            r_rd_zero <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_pc      <= n_pc;
            r_rd_zero <= n_rd_zero;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_v      <= n_v;
        r_w      <= n_w;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ----- rtl/core/memory_machine_instruction_executor.sv -----
// top level of the memory machine instruction executor
`timescale 1ns / 1ps

// executes one decoded instruction per transfer against a 1024-word data memory
// whose word 0 is the program counter. an instruction is taken when start is high
// and busy is low; its result (ok, halted, next_pc) shows on o_result for exactly
// one cycle with o_done high and must be taken then, the receiver cannot stall.
// operands come from the single-port data memory with registered read data: NOP,
// SET, HLT and undefined opcodes go from idle straight to execute, CPY, ADD and
// JIF make one operand read, and CPYI, ADDI and SUBI two dependent reads; busy
// drops in the cycle the result is shown, so the next transfer can overlap it.
// after reset a clearing pass writes zero to every word, one word a cycle, while
// busy stays high. the program counter is kept in a register beside the memory, so
// reads of word 0 are served from it and instruction writes to word 0 skip the ram
module memory_machine_instruction_executor (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  mmie_pkg::t_in    i_item,
    output logic             busy,
    output logic             o_done,
    output mmie_pkg::t_out   o_result
);

    mmie_pkg::t_mem_req               mem_req;
    logic [mmie_pkg::DATA_W-1:0]      mem_rdata;

    // sequencer: clearing sweep, operand fetch, execute and pc update
    mmie_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_item      (i_item),
        .busy        (busy),
        .o_done      (o_done),
        .o_result    (o_result),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata)
    );

    // data memory, one access per cycle
    mmie_ram #(
        .DEPTH (mmie_pkg::MEM_WORDS),
        .WIDTH (mmie_pkg::DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_re    (mem_req.re),
        .i_addr  (mem_req.addr),
        .i_wdata (mem_req.wdata),
        .o_rdata (mem_rdata)
    );

endmodule

// ----- test/memory_machine_instruction_executor_tb.sv -----
// testbench of the memory machine instruction executor: directed table, then random programs
`timescale 1ns / 1ps

// drives decoded instructions through the start/busy handshake and checks every
// o_done result against its written table result or the testbench's shadow memory.
// the directed table walks the opcodes, undefined opcodes, operand extremes,
// address wrap and the program counter special cases; the random part then runs
// three phases with different sender gaps, draining all results between phases
module memory_machine_instruction_executor_tb;

    localparam int CLK_HALF    = 5;
    localparam int RESET_CYCLES = 9;
    localparam int PHASE_ITEMS = 600;
    localparam int DRAIN_CYCLES = 8;
    // clearing pass plus ~1800 items at worst-case length and 66% sender gaps, several times over
    localparam int CYCLE_LIMIT = 200000;
    localparam int DIR_ROWS    = 25;

    // one row of the directed table; typed marks rows whose result is written out here
    typedef struct packed {
        mmie_pkg::t_in  item;
        logic           typed;
        mmie_pkg::t_out result;
    } t_dir_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    mmie_pkg::t_in    i_item;
    logic             busy;
    logic             o_done;
    mmie_pkg::t_out   o_result;

    // shadow of the data memory, word 0 is the program counter
    logic [mmie_pkg::DATA_W-1:0] shadow_mem [mmie_pkg::MEM_WORDS];
    // results still owed by the block, oldest first
    mmie_pkg::t_out              owed_results [$];

    int error_count;
    int accepted_count;
    int checked_count;
    int halt_count;
    int undef_count;
    int sender_idle_pct;

    // directed rows: pc values follow from a cleared memory, one step at a time
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{'{mmie_pkg::OP_NOP, 32'sd0, 32'sd0}, 1'b1, '{1'b1, 1'b0, 32'sd1}},
        // undefined opcodes, including the all-zero and all-one codes
        '{'{4'd0, 32'sd0, 32'sd0}, 1'b1, '{1'b0, 1'b0, 32'sd2}},
        '{'{4'd15, -32'sd1, -32'sd1}, 1'b1, '{1'b0, 1'b0, 32'sd3}},
        '{'{mmie_pkg::OP_HLT, 32'h7fffffff, 32'h80000000}, 1'b1, '{1'b1, 1'b1, 32'sd4}},
        '{'{4'd10, 32'h55555555, 32'haaaaaaaa}, 1'b1, '{1'b0, 1'b0, 32'sd5}},
        // operand extremes, negative address wraps to the top word
        '{'{mmie_pkg::OP_SET, 32'h7fffffff, 32'sd5}, 1'b1, '{1'b1, 1'b0, 32'sd6}},
        '{'{mmie_pkg::OP_SET, 32'h80000000, -32'sd1}, 1'b1, '{1'b1, 1'b0, 32'sd7}},
        // sum wraps into the sign bit
        '{'{mmie_pkg::OP_ADD, 32'sd1, 32'sd5}, 1'b1, '{1'b1, 1'b0, 32'sd8}},
        // address above the memory size wraps
        '{'{mmie_pkg::OP_CPY, 32'sd5, 32'sd1030}, 1'b1, '{1'b1, 1'b0, 32'sd9}},
        '{'{mmie_pkg::OP_ADDI, 32'sd1023, 32'sd6}, 1'b1, '{1'b1, 1'b0, 32'sd10}},
        '{'{mmie_pkg::OP_SUBI, 32'sd5, -32'sd1}, 1'b1, '{1'b1, 1'b0, 32'sd11}},
        // write to the counter, then rewrite it with the value it holds
        '{'{mmie_pkg::OP_SET, 32'sd20, 32'sd0}, 1'b1, '{1'b1, 1'b0, 32'sd20}},
        '{'{mmie_pkg::OP_SET, 32'sd20, 32'sd0}, 1'b1, '{1'b1, 1'b0, 32'sd21}},
        // jump taken on zero to its own index still advances
        '{'{mmie_pkg::OP_JIF, 32'sd6, 32'sd21}, 1'b1, '{1'b1, 1'b0, 32'sd22}},
        // jump taken on a negative word
        '{'{mmie_pkg::OP_JIF, 32'sd5, 32'h7fffffff}, 1'b1, '{1'b1, 1'b0, 32'h7fffffff}},
        // counter wraps into negative range
        '{'{mmie_pkg::OP_SET, 32'sd7, 32'sd300}, 1'b1, '{1'b1, 1'b0, 32'h80000000}},
        // jump not taken on a positive word
        '{'{mmie_pkg::OP_JIF, 32'sd300, 32'sd0}, 1'b1, '{1'b1, 1'b0, 32'h80000001}},
        '{'{mmie_pkg::OP_SET, -32'sd1, 32'sd0}, 1'b1, '{1'b1, 1'b0, 32'hffffffff}},
        // counter wraps to zero
        '{'{mmie_pkg::OP_NOP, 32'sd0, 32'sd0}, 1'b1, '{1'b1, 1'b0, 32'sd0}},
        '{'{mmie_pkg::OP_SET, 32'sd9, 32'sd301}, 1'b1, '{1'b1, 1'b0, 32'sd1}},
        '{'{mmie_pkg::OP_CPYI, 32'sd300, 32'sd302}, 1'b1, '{1'b1, 1'b0, 32'sd2}},
        // indirect copy into the counter, add and subtract on the counter itself
        '{'{mmie_pkg::OP_CPYI, 32'sd301, 32'sd0}, 1'b0, '0},
        '{'{mmie_pkg::OP_ADD, -32'sd5, 32'h80000000}, 1'b0, '0},
        '{'{mmie_pkg::OP_SUBI, 32'sd0, 32'sd0}, 1'b0, '0},
        '{'{mmie_pkg::OP_ADDI, 32'sd1023, 32'h80000000}, 1'b0, '0}
    };

    memory_machine_instruction_executor uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial i_clk = 1'b0;
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // executes one instruction on the shadow memory and returns what the block should show
    function automatic mmie_pkg::t_out execute_instr(input mmie_pkg::t_in instr);
        logic [mmie_pkg::DATA_W-1:0] src;
        logic [mmie_pkg::DATA_W-1:0] dst;
        logic [mmie_pkg::DATA_W-1:0] pc_prev;
        logic [mmie_pkg::DATA_W-1:0] word;
        logic [mmie_pkg::ADDR_W-1:0] sa;
        logic [mmie_pkg::ADDR_W-1:0] da;
        mmie_pkg::t_out              res;
        src     = instr.first_operand;
        dst     = instr.second_operand;
        sa      = src[mmie_pkg::ADDR_W-1:0];
        da      = dst[mmie_pkg::ADDR_W-1:0];
        pc_prev = shadow_mem[0];
        res     = '{ok: 1'b1, halted: 1'b0, next_pc: '0};
        case (instr.kind)
            mmie_pkg::OP_NOP: ;
            mmie_pkg::OP_SET: shadow_mem[da] = src;
            mmie_pkg::OP_CPY: shadow_mem[da] = shadow_mem[sa];
            mmie_pkg::OP_CPYI: begin
                word = shadow_mem[sa];
                shadow_mem[da] = shadow_mem[word[mmie_pkg::ADDR_W-1:0]];
            end
            mmie_pkg::OP_ADD:  shadow_mem[da] = shadow_mem[da] + src;
            mmie_pkg::OP_ADDI: shadow_mem[da] = shadow_mem[sa] + shadow_mem[da];
            mmie_pkg::OP_SUBI: shadow_mem[da] = shadow_mem[sa] - shadow_mem[da];
            mmie_pkg::OP_JIF: begin
                // taken when the word is zero or negative
                word = shadow_mem[sa];
                if ($signed(word) <= 0) begin
                    shadow_mem[0] = dst;
                end
            end
            mmie_pkg::OP_HLT: res.halted = 1'b1;
            default: res.ok = 1'b0;
        endcase
        // counter left as it was advances by one, whatever was written to it
        if (shadow_mem[0] == pc_prev) begin
            shadow_mem[0] = pc_prev + 1'b1;
        end
        res.next_pc = shadow_mem[0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // one transfer: optional sender gaps, then start held until busy is low at an edge
    task automatic send_instr(input mmie_pkg::t_in instr, input logic typed,
                              input mmie_pkg::t_out typed_res);
        mmie_pkg::t_out predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= instr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // transfer happened at this edge
        predicted = execute_instr(instr);
        owed_results.push_back(typed ? typed_res : predicted);
        accepted_count++;
        if (instr.kind == mmie_pkg::OP_HLT) halt_count++;
        if (!predicted.ok) undef_count++;
    endtask

    // sender holds off until every owed result has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (owed_results.size() != 0) @(posedge i_clk);
    endtask

    // address operand: mostly a handful of hot words so instructions depend on each other,
    // upper bits usually random since only the low bits select the word
    function automatic logic [31:0] rand_addr();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(3))
            0, 1: v[mmie_pkg::ADDR_W-1:0] = mmie_pkg::ADDR_W'($urandom_range(15));
            2:    v = $urandom_range(15);
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_value();
        logic [31:0] v;
        case ($urandom_range(7))
            0: v = 32'h7fffffff;
            1: v = 32'h80000000;
            2: v = 32'hffffffff;
            3: v = '0;
            4, 5: v = $urandom_range(31) - 16;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic mmie_pkg::t_in rand_instr();
        mmie_pkg::t_in instr;
        // a few undefined opcodes among mostly defined ones
        if ($urandom_range(19) == 0) begin
            instr.kind = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(15, 10));
        end else begin
            instr.kind = 4'($urandom_range(mmie_pkg::OP_HLT, mmie_pkg::OP_NOP));
        end
        if (instr.kind == mmie_pkg::OP_SET || instr.kind == mmie_pkg::OP_ADD) begin
            instr.first_operand = rand_value();
        end else begin
            instr.first_operand = rand_addr();
        end
        // jump targets stay small most of the time so the counter revisits low values
        if (instr.kind == mmie_pkg::OP_JIF && $urandom_range(1) == 0) begin
            instr.second_operand = $urandom_range(31);
        end else begin
            instr.second_operand = rand_addr();
        end
        return instr;
    endfunction

    // result checker: a result is only valid in its o_done cycle
    always @(posedge i_clk) begin
        mmie_pkg::t_out want;
        if (i_rst_n && o_done) begin
            if (owed_results.size() == 0) begin
                $display("%0t unexpected result: ok %b halted %b next_pc %h", $realtime,
                         o_result.ok, o_result.halted, o_result.next_pc);
                error_count++;
            end else begin
                want = owed_results.pop_front();
                checked_count++;
                if (o_result.ok !== want.ok) begin
                    report_mismatch("ok", 32'(o_result.ok), 32'(want.ok));
                end
                if (o_result.halted !== want.halted) begin
                    report_mismatch("halted", 32'(o_result.halted), 32'(want.halted));
                end
                if (o_result.next_pc !== want.next_pc) begin
                    report_mismatch("next_pc", o_result.next_pc, want.next_pc);
                end
            end
        end
    end

    // watchdog
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results owed", cycles, owed_results.size());
        $display("memory_machine_instruction_executor_tb: done, errors");
        $finish;
    end

    initial begin
        int wait_cycles;
        error_count     = 0;
        accepted_count  = 0;
        checked_count   = 0;
        halt_count      = 0;
        undef_count     = 0;
        sender_idle_pct = 0;
        for (int w = 0; w < mmie_pkg::MEM_WORDS; w++) shadow_mem[w] = '0;

        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the clearing pass keeps busy high, the first transfer simply waits for it

        // directed table, back to back
        for (int r = 0; r < DIR_ROWS; r++) begin
            send_instr(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].result);
        end
        drain_results();

        // random programs: light sender gaps, heavy gaps, then none
        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 66 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_instr(rand_instr(), 1'b0, '0);
            end
            drain_results();
        end

        // let any stray result show up
        wait_cycles = 0;
        while (wait_cycles < DRAIN_CYCLES) begin
            @(posedge i_clk);
            wait_cycles++;
        end

        $display("executed %0d instructions (%0d checked), %0d halts, %0d undefined opcodes",
                 accepted_count, checked_count, halt_count, undef_count);
        $display("directed opcode sweep, then random programs with 10%%, 66%% and no sender gaps");
        if (error_count == 0 && owed_results.size() == 0) begin
            $display("memory_machine_instruction_executor_tb: done, clean");
        end else begin
            $display("memory_machine_instruction_executor_tb: done, errors");
        end
        $finish;
    end

endmodule
